@@ rtl/bf3_pkg.sv @@
package bf3_pkg;

    // Register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Field widths
    localparam int IMAGE_WIDTH_W  = 11;
    localparam int IMAGE_HEIGHT_W = 13;
    localparam int ROW_W          = 12;
    localparam int PIXEL_PORT_W   = 16;
    localparam int MEAN_W         = 16;

    // Frame size limits
    localparam int MIN_SIZE     = 3;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RESET_SIZE   = 1024;

    // floor(x / 9) = (x * DIV9_MUL) >> DIV9_SHIFT, exact for x < 2**21
    localparam int DIV9_MUL_W = 20;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 20'd932068;
    localparam int DIV9_SHIFT = 23;

    // Per-request position flags carried down the pipeline
    typedef struct packed {
        logic result;
        logic row_end;
        logic frame_end;
    } t_pos_flags;

endpackage

@@ rtl/bf3_ram.sv @@
module bf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds its data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/box_filter_3x3_top.sv @@
// A pixel request is registered into stage 1 together with its line store reads, its
// window sum into stage 2, and its mean into the output register on the result ports.
// Throughput: one pixel per cycle unless results stall, set by one read and one write
// of each line store per column (read at acceptance, write-back on stage 1 advance).
// Reset (i_rst_n low, synchronous): position counters cleared, frame size back to
// 1024 x 1024, pipeline emptied; line stores and window keep whatever they hold.
module box_filter_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_wr_en,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Pixel input channel
    input  logic                                 i_pixel_valid,
    output logic                                 o_pixel_stall,
    input  logic [bf3_pkg::PIXEL_PORT_W-1:0]     i_pixel,
    // Result output channel
    output logic                                 o_result_valid,
    input  logic                                 i_result_stall,
    output logic [bf3_pkg::MEAN_W-1:0]           o_mean_value,
    output logic                                 o_row_end,
    output logic                                 o_frame_end
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SUM_W   = PIXEL_BITS + 4;
    localparam int PROD_W  = SUM_W + bf3_pkg::DIV9_MUL_W;
    localparam int RST_W   = (bf3_pkg::RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH
                                                                 : bf3_pkg::RESET_SIZE;
    localparam logic [COL_W-1:0]          RST_COL_LAST = COL_W'(RST_W - 1);
    localparam logic [bf3_pkg::ROW_W-1:0] RST_ROW_LAST =
        bf3_pkg::ROW_W'(bf3_pkg::RESET_SIZE - 1);

    // Frame geometry, kept as last column / last row
    logic [COL_W-1:0]          r_col_last, n_col_last;
    logic [bf3_pkg::ROW_W-1:0] r_row_last, n_row_last;

    // Position of the next pixel
    logic [COL_W-1:0]          r_col;
    logic [bf3_pkg::ROW_W-1:0] r_row;

    // Stage 1: line store data arrives, window sum
    logic                      r_v1;
    logic [COL_W-1:0]          r_col1;
    logic [PIXEL_BITS-1:0]     r_pix1;
    bf3_pkg::t_pos_flags       r_flags1;

    // Stage 2: sum waiting for the divide
    logic                      r_v2;
    logic [SUM_W-1:0]          r_sum2;
    bf3_pkg::t_pos_flags       r_flags2;

    // Output register
    logic                      r_v3;
    logic [bf3_pkg::MEAN_W-1:0] r_mean3;
    logic                      r_row_end3;
    logic                      r_frame_end3;

    // Window: [0..2] older column top..bottom, [3..5] newer column
    logic [PIXEL_BITS-1:0]     r_win [6];

    logic                      adv1, adv2, adv3;
    logic                      in_accept, s1_fire;
    logic [PIXEL_BITS-1:0]     top_rd, mid_rd, cur_pix;
    logic [SUM_W-1:0]          sum1;
    logic [PROD_W-1:0]         prod2;
    bf3_pkg::t_pos_flags       flags0;

    // Bubble-collapsing advance chain
    assign adv3      = ~r_v3 | ~i_result_stall;
    assign adv2      = ~r_v2 | adv3;
    assign adv1      = ~r_v1 | adv2;
    assign o_pixel_stall = ~adv1;
    assign in_accept = i_pixel_valid & adv1;
    assign s1_fire   = r_v1 & adv2;

    // Clamp written sizes to their legal ranges
    always_comb begin
        int w;
        int h;
        w = int'(i_cfg_data[bf3_pkg::IMAGE_WIDTH_W-1:0]);
        h = int'(i_cfg_data[bf3_pkg::IMAGE_HEIGHT_W-1:0]);
        if (w < bf3_pkg::MIN_SIZE) w = bf3_pkg::MIN_SIZE;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < bf3_pkg::MIN_SIZE) h = bf3_pkg::MIN_SIZE;
        if (h > bf3_pkg::HEIGHT_LIMIT) h = bf3_pkg::HEIGHT_LIMIT;
        n_col_last = COL_W'(w - 1);
        n_row_last = bf3_pkg::ROW_W'(h - 1);
    end

    // Configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= RST_COL_LAST;
            r_row_last <= RST_ROW_LAST;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bf3_pkg::CFG_IMAGE_WIDTH:  r_col_last <= n_col_last;
                bf3_pkg::CFG_IMAGE_HEIGHT: r_row_last <= n_row_last;
                default: ;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                r_row <= (r_row == r_row_last) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Position flags of the incoming pixel
    always_comb begin
        flags0.result    = (r_col >= COL_W'(2)) && (r_row >= bf3_pkg::ROW_W'(2));
        flags0.row_end   = (r_col == r_col_last);
        flags0.frame_end = (r_col == r_col_last) && (r_row == r_row_last);
    end

    // Line stores: read at acceptance, written back when stage 1 moves on.
    // Back-to-back requests touch different columns, so no read/write overlap.
    bf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_col1),
        .i_wr_data (mid_rd),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (top_rd)
    );

    bf3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_col1),
        .i_wr_data (r_pix1),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    assign cur_pix = i_pixel[PIXEL_BITS-1:0];

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= i_pixel_valid;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col1   <= r_col;
            r_pix1   <= cur_pix;
            r_flags1 <= flags0;
        end
    end

    // Nine-pixel sum at full width
    assign sum1 = SUM_W'(r_win[0]) + SUM_W'(r_win[1]) + SUM_W'(r_win[2])
                + SUM_W'(r_win[3]) + SUM_W'(r_win[4]) + SUM_W'(r_win[5])
                + SUM_W'(top_rd)   + SUM_W'(mid_rd)   + SUM_W'(r_pix1);

    // Window shift
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_rd;
            r_win[4] <= mid_rd;
            r_win[5] <= r_pix1;
        end
    end

    // Stage 2 control: only border-free positions go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1 & r_flags1.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_sum2   <= sum1;
            r_flags2 <= r_flags1;
        end
    end

    // Divide by nine via reciprocal multiply
    assign prod2 = PROD_W'(r_sum2) * PROD_W'(bf3_pkg::DIV9_MUL);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r_mean3      <= bf3_pkg::MEAN_W'(prod2[bf3_pkg::DIV9_SHIFT +: PIXEL_BITS]);
            r_row_end3   <= r_flags2.row_end;
            r_frame_end3 <= r_flags2.frame_end;
        end
    end

    assign o_result_valid = r_v3;
    assign o_mean_value   = r_mean3;
    assign o_row_end      = r_row_end3;
    assign o_frame_end    = r_frame_end3;

endmodule
